FILE: rtl/assert_macros.svh
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, skipped while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_CLK_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/fpa_pkg.sv
`timescale 1ns / 1ps

package fpa_pkg;

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_GT       = 4'd4;
  localparam logic [3:0] OP_LT       = 4'd5;
  localparam logic [3:0] OP_GE       = 4'd6;
  localparam logic [3:0] OP_LE       = 4'd7;
  localparam logic [3:0] OP_EQ       = 4'd8;
  localparam logic [3:0] OP_NE       = 4'd9;
  localparam logic [3:0] OP_MIN      = 4'd10;
  localparam logic [3:0] OP_MAX      = 4'd11;
  localparam logic [3:0] OP_INC      = 4'd12;
  localparam logic [3:0] OP_DEC      = 4'd13;
  localparam logic [3:0] OP_TO_INT   = 4'd14;
  localparam logic [3:0] OP_FROM_INT = 4'd15;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;

  // result so far, carried alongside the divider stages
  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] res;
    logic        cmp;
    logic [1:0]  status;
    logic        neg;
  } side_t;

endpackage

FILE: rtl/fixed_point_alu_q24_8.sv
`timescale 1ns / 1ps
// a request passes operand capture, stage 1, the divider stages and the output stage in turn
// throughput: one request per cycle while the output is not stalled, set by the bit-per-stage divider pipeline
// a stall at the output freezes every stage at once, nothing is dropped
// reset clears the valid bits of all stages, payload registers are not reset

module fixed_point_alu_q24_8 #(
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  s_tuser,   // req_type [3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result_value [31:0], compare_true [32], status [34:33]
);

  localparam int NUMW = 32 + FRACTION_BITS;

  logic adv;

  // stage 0: operand capture
  logic              v0;
  logic [3:0]        op0;
  logic signed [31:0] a0, b0;

  // stage 1: simple ops, product, divider setup
  logic               v1;
  fpa_pkg::side_t     sb1, sb1_next;
  logic signed [63:0] p1;
  logic [NUMW-1:0]    num1;
  logic [31:0]        den1;

  // divider stages
  logic                  vd  [NUMW];
  fpa_pkg::side_t        sbd [NUMW];
  logic [31:0]           rd  [NUMW];
  logic [NUMW-1:0]       nd  [NUMW];
  logic [NUMW-1:0]       qd  [NUMW];
  logic [31:0]           dd  [NUMW];

  fpa_pkg::side_t sb_mul;

  // output stage
  logic           vo;
  fpa_pkg::side_t sbo, sbo_next;

  assign adv      = !vo || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vo;
  assign m_tdata  = {5'd0, sbo.status, sbo.cmp, sbo.res};

  function automatic logic [32:0] sat33(input logic [32:0] s);
    // returns {overflow, value}
    if (s[32] != s[31]) begin
      return {1'b1, s[32] ? fpa_pkg::VAL_MIN : fpa_pkg::VAL_MAX};
    end
    return {1'b0, s[31:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0 <= s_tuser;
      a0  <= s_tdata[31:0];
      b0  <= s_tdata[63:32];
    end
  end

  logic [32:0]        sum_ab, dif_ab, inc_a, dec_a, sat_r;
  logic [31:0]        mag_a, mag_b;
  logic signed [63:0] fi_wide;

  always_comb begin
    sum_ab  = sat33({a0[31], a0} + {b0[31], b0});
    dif_ab  = sat33({a0[31], a0} - {b0[31], b0});
    inc_a   = sat33({a0[31], a0} + 33'd1);
    dec_a   = sat33({a0[31], a0} - 33'd1);
    mag_a   = a0[31] ? 32'(-a0) : a0;
    mag_b   = b0[31] ? 32'(-b0) : b0;
    fi_wide = 64'(a0) <<< FRACTION_BITS;
    sat_r   = 33'd0;
    sb1_next        = '0;
    sb1_next.op     = op0;
    sb1_next.neg    = a0[31] ^ b0[31];
    unique case (op0)
      fpa_pkg::OP_ADD: sat_r = sum_ab;
      fpa_pkg::OP_SUB: sat_r = dif_ab;
      fpa_pkg::OP_INC: sat_r = inc_a;
      fpa_pkg::OP_DEC: sat_r = dec_a;
      fpa_pkg::OP_MUL: sat_r = 33'd0;
      fpa_pkg::OP_DIV: begin
        if (b0 == 32'sd0) begin
          sb1_next.status = fpa_pkg::ST_DZ;
          sat_r = {1'b0, (a0 > 0) ? fpa_pkg::VAL_MAX : ((a0 < 0) ? fpa_pkg::VAL_MIN : 32'd0)};
        end
      end
      fpa_pkg::OP_GT: sb1_next.cmp = a0 > b0;
      fpa_pkg::OP_LT: sb1_next.cmp = a0 < b0;
      fpa_pkg::OP_GE: sb1_next.cmp = a0 >= b0;
      fpa_pkg::OP_LE: sb1_next.cmp = a0 <= b0;
      fpa_pkg::OP_EQ: sb1_next.cmp = a0 == b0;
      fpa_pkg::OP_NE: sb1_next.cmp = a0 != b0;
      fpa_pkg::OP_MIN: sat_r = {1'b0, (a0 < b0) ? a0 : b0};
      fpa_pkg::OP_MAX: sat_r = {1'b0, (a0 > b0) ? a0 : b0};
      fpa_pkg::OP_TO_INT: sat_r = {1'b0, a0 >>> FRACTION_BITS};
      fpa_pkg::OP_FROM_INT: begin
        if (fi_wide > 64'sh7fff_ffff || fi_wide < -64'sh8000_0000) begin
          sat_r = {1'b1, a0[31] ? fpa_pkg::VAL_MIN : fpa_pkg::VAL_MAX};
        end else begin
          sat_r = {1'b0, fi_wide[31:0]};
        end
      end
      default: sat_r = 33'd0;
    endcase
    sb1_next.res = sat_r[31:0];
    if (sat_r[32]) begin
      sb1_next.status = fpa_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb1  <= sb1_next;
      p1   <= a0 * b0;
      num1 <= NUMW'(mag_a) << FRACTION_BITS;
      den1 <= mag_b;
    end
  end

  // product rounding, half away from zero, then saturation
  logic [63:0] p_mag, p_rnd;
  logic [63:0] half;

  always_comb begin
    half   = (64'd1 << FRACTION_BITS) >> 1;
    p_mag  = p1[63] ? 64'(-p1) : 64'(p1);
    p_rnd  = (p_mag + half) >> FRACTION_BITS;
    sb_mul = sb1;
    if (sb1.op == fpa_pkg::OP_MUL) begin
      if (p1[63]) begin
        if (p_rnd > 64'h8000_0000) begin
          sb_mul.res    = fpa_pkg::VAL_MIN;
          sb_mul.status = fpa_pkg::ST_SAT;
        end else begin
          sb_mul.res = 32'(-p_rnd[31:0]);
        end
      end else if (p_rnd > 64'h7fff_ffff) begin
        sb_mul.res    = fpa_pkg::VAL_MAX;
        sb_mul.status = fpa_pkg::ST_SAT;
      end else begin
        sb_mul.res = p_rnd[31:0];
      end
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < NUMW; k++) begin : g_div
    logic [31:0]     r_in, d_in;
    logic [NUMW-1:0] n_in, q_in;
    logic [32:0]     trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign r_in = 32'd0;
      assign n_in = num1;
      assign q_in = '0;
      assign d_in = den1;
    end else begin : g_rest
      assign r_in = rd[k-1];
      assign n_in = nd[k-1];
      assign q_in = qd[k-1];
      assign d_in = dd[k-1];
    end

    assign trial = {r_in, n_in[NUMW-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k] <= 1'b0;
      end else if (adv) begin
        vd[k] <= (k == 0) ? v1 : vd[k-1 < 0 ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sbd[k] <= (k == 0) ? sb_mul : sbd[k-1 < 0 ? 0 : k-1];
        rd[k]  <= ge ? 32'(trial - {1'b0, d_in}) : trial[31:0];
        nd[k]  <= n_in << 1;
        qd[k]  <= {q_in[NUMW-2:0], ge};
        dd[k]  <= d_in;
      end
    end
  end

  // quotient rounding and saturation
  logic [NUMW:0] q_rnd;
  logic          rnd_up;
  fpa_pkg::side_t sb_last;

  always_comb begin
    sb_last  = sbd[NUMW-1];
    rnd_up   = {rd[NUMW-1], 1'b0} >= {1'b0, dd[NUMW-1]};
    q_rnd    = {1'b0, qd[NUMW-1]} + (NUMW+1)'(rnd_up);
    sbo_next = sb_last;
    if (sb_last.op == fpa_pkg::OP_DIV && sb_last.status != fpa_pkg::ST_DZ) begin
      if (sb_last.neg) begin
        if (q_rnd > (NUMW+1)'(33'h0_8000_0000)) begin
          sbo_next.res    = fpa_pkg::VAL_MIN;
          sbo_next.status = fpa_pkg::ST_SAT;
        end else begin
          sbo_next.res = 32'(-q_rnd[31:0]);
        end
      end else if (q_rnd > (NUMW+1)'(33'h0_7fff_ffff)) begin
        sbo_next.res    = fpa_pkg::VAL_MAX;
        sbo_next.status = fpa_pkg::ST_SAT;
      end else begin
        sbo_next.res = q_rnd[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (adv) begin
      vo <= vd[NUMW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sbo <= sbo_next;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_cmp_only_compare, vo && sbo.cmp |-> (sbo.op == fpa_pkg::OP_GT || sbo.op == fpa_pkg::OP_LT || sbo.op == fpa_pkg::OP_GE || sbo.op == fpa_pkg::OP_LE || sbo.op == fpa_pkg::OP_EQ || sbo.op == fpa_pkg::OP_NE), "compare flag on a non-compare request")
  `ASSERT_CLK(a_sat_limit, vo && sbo.status == fpa_pkg::ST_SAT |-> (sbo.res == fpa_pkg::VAL_MAX || sbo.res == fpa_pkg::VAL_MIN), "saturated result not at a limit")
  `ASSERT_CLK(a_dz_div, vo && sbo.status == fpa_pkg::ST_DZ |-> sbo.op == fpa_pkg::OP_DIV, "divide by zero flag on a non-divide request")
  `ASSERT_CLK_ANY(a_reset_idle, rst |=> !vo, "output valid right after reset")

endmodule

FILE: sim/fixed_point_alu_q24_8_test.sv
`timescale 1ns / 1ps

module fixed_point_alu_q24_8_test;

  localparam int FB = 8;
  localparam int LATENCY = 2 + 32 + FB;
  localparam int N_RANDOM = 1950;

  typedef struct packed {
    logic [1:0]  status;
    logic        cmp;
    logic [31:0] value;
  } alu_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int n_errors = 0;

  always #5 clk = ~clk;

  fixed_point_alu_q24_8 #(.FRACTION_BITS(FB)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic logic [31:0] clamp32(input logic signed [65:0] v, inout logic [1:0] st);
    if (v > 66'sh0_7fff_ffff) begin
      st = fpa_pkg::ST_SAT;
      return fpa_pkg::VAL_MAX;
    end
    if (v < -66'sh0_8000_0000) begin
      st = fpa_pkg::ST_SAT;
      return fpa_pkg::VAL_MIN;
    end
    return v[31:0];
  endfunction

  // exact fixed-point arithmetic, rounding half away from zero
  function automatic alu_result_t alu_compute(input logic [3:0] op,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    alu_result_t r;
    logic signed [65:0] wa, wb, p;
    logic [65:0] mag, num, den, q;
    logic neg;
    r = '0;
    wa = a;
    wb = b;
    case (op)
      fpa_pkg::OP_ADD: r.value = clamp32(wa + wb, r.status);
      fpa_pkg::OP_SUB: r.value = clamp32(wa - wb, r.status);
      fpa_pkg::OP_MUL: begin
        p = wa * wb;
        neg = p < 0;
        mag = neg ? -p : p;
        mag = (mag + (FB > 0 ? (66'd1 << (FB - 1)) : 66'd0)) >> FB;
        r.value = clamp32(neg ? -$signed(mag) : $signed(mag), r.status);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.status = fpa_pkg::ST_DZ;
          r.value = a > 0 ? fpa_pkg::VAL_MAX : (a < 0 ? fpa_pkg::VAL_MIN : 32'd0);
        end else begin
          num = (wa < 0 ? -wa : wa) << FB;
          den = wb < 0 ? -wb : wb;
          q = (2 * num + den) / (2 * den);
          neg = (a < 0) != (b < 0);
          r.value = clamp32(neg ? -$signed(q) : $signed(q), r.status);
        end
      end
      fpa_pkg::OP_GT: r.cmp = a > b;
      fpa_pkg::OP_LT: r.cmp = a < b;
      fpa_pkg::OP_GE: r.cmp = a >= b;
      fpa_pkg::OP_LE: r.cmp = a <= b;
      fpa_pkg::OP_EQ: r.cmp = a == b;
      fpa_pkg::OP_NE: r.cmp = a != b;
      fpa_pkg::OP_MIN: r.value = a < b ? a : b;
      fpa_pkg::OP_MAX: r.value = a > b ? a : b;
      fpa_pkg::OP_INC: r.value = clamp32(wa + 1, r.status);
      fpa_pkg::OP_DEC: r.value = clamp32(wa - 1, r.status);
      fpa_pkg::OP_TO_INT: r.value = a >>> FB;
      default: r.value = clamp32(wa <<< FB, r.status);
    endcase
    return r;
  endfunction

  class alu_scoreboard;
    alu_result_t pending[$];

    function void note_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
      pending.push_back(alu_compute(op, a, b));
    endfunction

    task check_result(logic [39:0] d);
      alu_result_t want, got;
      got = d[34:0];
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value)
        report($sformatf("result_value %h, wanted %h", got.value, want.value));
      if (got.cmp !== want.cmp)
        report($sformatf("compare_true %b, wanted %b", got.cmp, want.cmp));
      if (got.status !== want.status)
        report($sformatf("status %0d, wanted %0d", got.status, want.status));
    endtask
  endclass

  alu_scoreboard sb = new();

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_request(input logic [3:0] op, input logic [31:0] a,
                              input logic [31:0] b, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(op, a, b);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return fpa_pkg::VAL_MAX - $urandom_range(0, 2);
      1: return fpa_pkg::VAL_MIN + $urandom_range(0, 2);
      2: return $urandom_range(0, 4) - 2;
      3: return ($urandom_range(0, 600) - 300) << FB;
      4: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
      5: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // receiver backpressure
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      if ($urandom_range(0, 99) < 30) begin
        g = gap_len();
        m_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    logic [31:0] edges[6];
    logic [31:0] a, b;
    edges = '{fpa_pkg::VAL_MAX, fpa_pkg::VAL_MIN, 32'd0, 32'hffff_ffff, 32'd1,
              32'h0000_0100};
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // every operation once on edge operands
    for (int op = 0; op < 16; op++)
      send_request(op[3:0], edges[op % 6], edges[(op + 1) % 6], 1'b0);
    send_request(fpa_pkg::OP_DIV, 32'd5, 32'd0, 1'b0);
    send_request(fpa_pkg::OP_DIV, 32'hffff_fffb, 32'd0, 1'b0);
    send_request(fpa_pkg::OP_DIV, 32'd0, 32'd0, 1'b0);
    send_request(fpa_pkg::OP_DIV, 32'd1, 32'd2, 1'b0);
    send_request(fpa_pkg::OP_DIV, 32'hffff_ffff, 32'd2, 1'b0);
    send_request(fpa_pkg::OP_MUL, 32'h0000_0180, 32'h0000_0001, 1'b0);
    send_request(fpa_pkg::OP_MUL, 32'hffff_fe80, 32'h0000_0001, 1'b0);
    send_request(fpa_pkg::OP_GE, 32'd7, 32'd7, 1'b0);
    send_request(fpa_pkg::OP_LE, 32'd7, 32'd7, 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // let the pipeline drain completely before carrying on
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
      a = pick_operand();
      b = $urandom_range(0, 15) == 0 ? 32'd0 : pick_operand();
      if ($urandom_range(0, 7) == 0) b = a;
      send_request(4'($urandom_range(0, 15)), a, b, i >= 300);
    end
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (n_errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
